FILE: rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;

    // request kinds (tuser on the input side)
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    // result status (tuser on the output side)
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

FILE: rtl/ple_cell.sv
// One list cell: holds one entry and shifts it to or from its neighbours.
module ple_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                              clk,
    input  ple_pkg::cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]                  pos_idx,
    input  logic [IDX_W-1:0]                  last_idx,
    input  logic signed [ple_pkg::DATA_W-1:0] left,
    input  logic signed [ple_pkg::DATA_W-1:0] right,
    input  logic signed [ple_pkg::DATA_W-1:0] wrap,
    output logic signed [ple_pkg::DATA_W-1:0] data,
    output logic signed [ple_pkg::DATA_W-1:0] tap
);
    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INS:
            begin
                if (MY_IDX == pos_idx)
                    data_next = ctl.value;
                else if (MY_IDX > pos_idx)
                    data_next = left;
            end
            OP_DEL:
            begin
                if (MY_IDX >= pos_idx)
                    data_next = right;
            end
            OP_ROT:
            begin
                // the tail of the rotation takes the old head
                data_next = (MY_IDX == last_idx) ? wrap : right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (MY_IDX == pos_idx) ? data_reg : '0;

endmodule

FILE: rtl/positional_list_engine_core.sv
// Top level of the positional list engine: request control and the chain of cells.
//
//  channel  | direction | tdata (low bit up)                   | tuser   | tlast
//  s_axis   | in        | position[4:0], value[36:5], pad      | req     | -
//  m_axis   | out       | item_value[31:0], entry_count[36:32] | status  | last
//
// Insert and delete act at once: every cell at or past the position shifts together.
// A dump of N entries enters the dump state, then gives one entry a cycle while the
// output is free, read from the head cell as the chain rotates back to its original order.
// Reset clears the count and control; cell contents are not cleared.
// A stalled output holds the result; no new request is taken until the slot frees.
module positional_list_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // item_value[31:0], entry_count[36:32], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);
    import ple_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic                     mvalid_reg, mvalid_next;
    logic signed [DATA_W-1:0] mitem_reg, mitem_next;
    logic [CNT_W-1:0]         mcount_reg, mcount_next;
    logic [1:0]               mstatus_reg, mstatus_next;
    logic                     mlast_reg, mlast_next;

    logic [1:0]               req;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic [CMP_W-1:0]         pos_w, cnt_w;
    logic                     out_free, accept;
    logic                     ins_range_bad, del_range_bad, is_full;
    logic [IDX_W-1:0]         pos_idx, last_idx;
    cell_ctl_t                ctl;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_tap  [DEPTH];
    logic signed [DATA_W-1:0] removed;

    assign req      = s_axis_tuser;
    assign position = s_axis_tdata[POS_W-1:0];
    assign value    = s_axis_tdata[POS_W+DATA_W-1:POS_W];

    assign out_free      = !mvalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos_w         = CMP_W'(position);
    assign cnt_w         = CMP_W'(count_reg);
    assign ins_range_bad = (pos_w == '0) || (pos_w > cnt_w + CMP_W'(1));
    assign del_range_bad = (pos_w == '0) || (pos_w > cnt_w);
    assign is_full       = (cnt_w == CMP_W'(DEPTH));
    assign pos_idx       = IDX_W'(pos_w - CMP_W'(1));
    assign last_idx      = IDX_W'(cnt_w - CMP_W'(1));

    // removed entry: one-hot taps from the cells, or-reduced
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++)
            removed = removed | cell_tap[i];
    end

    always_comb
    begin
        ctl.op    = OP_HOLD;
        ctl.value = value;
        if (accept && req == REQ_INSERT && !ins_range_bad && !is_full)
            ctl.op = OP_INS;
        else if (accept && req == REQ_DELETE && !del_range_bad)
            ctl.op = OP_DEL;
        else if (state_reg == S_DUMP && out_free)
            ctl.op = OP_ROT;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        mvalid_next  = mvalid_reg && !m_axis_tready;
        mitem_next   = mitem_reg;
        mcount_next  = mcount_reg;
        mstatus_next = mstatus_reg;
        mlast_next   = mlast_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mlast_next = 1'b1;
                    mitem_next = '0;
                    case (req)
                        REQ_INSERT:
                        begin
                            mvalid_next = 1'b1;
                            if (ins_range_bad)
                            begin
                                mstatus_next = ST_RANGE;
                                mcount_next  = count_reg;
                            end
                            else if (is_full)
                            begin
                                mstatus_next = ST_FULL;
                                mcount_next  = count_reg;
                            end
                            else
                            begin
                                mstatus_next = ST_OK;
                                mitem_next   = value;
                                count_next   = count_reg + CNT_W'(1);
                                mcount_next  = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            mvalid_next = 1'b1;
                            if (del_range_bad)
                            begin
                                mstatus_next = ST_RANGE;
                                mcount_next  = count_reg;
                            end
                            else
                            begin
                                mstatus_next = ST_OK;
                                mitem_next   = removed;
                                count_next   = count_reg - CNT_W'(1);
                                mcount_next  = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                mvalid_next  = 1'b1;
                                mstatus_next = ST_EMPTY;
                                mcount_next  = count_reg;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused request code: dropped without a result
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    mvalid_next  = 1'b1;
                    mitem_next   = cell_data[0];
                    mcount_next  = count_reg;
                    mstatus_next = ST_OK;
                    mlast_next   = (remain_reg == CNT_W'(1));
                    remain_next  = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            mvalid_reg  <= 1'b0;
            mitem_reg   <= '0;
            mcount_reg  <= '0;
            mstatus_reg <= ST_OK;
            mlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            mvalid_reg  <= mvalid_next;
            mitem_reg   <= mitem_next;
            mcount_reg  <= mcount_next;
            mstatus_reg <= mstatus_next;
            mlast_reg   <= mlast_next;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in, right_in;
        if (g == 0)
        begin : g_head
            assign left_in = value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_tail
            assign right_in = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[g+1];
        end

        ple_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .pos_idx  (pos_idx),
            .last_idx (last_idx),
            .left     (left_in),
            .right    (right_in),
            .wrap     (cell_data[0]),
            .data     (cell_data[g]),
            .tap      (cell_tap[g])
        );
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {3'b000, COUNT_W'(mcount_reg), mitem_reg};
    assign m_axis_tuser  = mstatus_reg;
    assign m_axis_tlast  = mlast_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_dump_remain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> remain_reg != '0)
        else $error("dump running with nothing left");

    a_partial_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && !mlast_reg) |-> state_reg == S_DUMP)
        else $error("non-final result outside a dump");

    a_count_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count moved without a request");

endmodule
